/* hdl/absa_pkg.sv */
// Shared constants, codes and types for the aligned buffer slot allocator.
// No dependencies; every other file imports this package.
package absa_pkg;

    localparam int MAX_SLOTS  = 64;
    localparam int SLOT_ALIGN = 64;

    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
    localparam int ALIGN_W  = $clog2(SLOT_ALIGN);
    localparam int ADDR_W   = 64;
    localparam int LEN_W    = 32;
    localparam int SIZE_W   = 16;
    localparam int STRIDE_W = SIZE_W + 1;
    localparam int OFF_W    = STRIDE_W + SLOT_W;
    localparam int ACC_W    = OFF_W + 1;
    localparam int STEP_W   = $clog2(SLOT_W);

    localparam int S_TDATA_W  = ADDR_W;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 152;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        OP_REBUILD,
        OP_GET,
        OP_RETURN,
        OP_NONE
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_FREE,
        ST_NONE_IN_USE,
        ST_NO_MATCH
    } status_t;

    typedef enum logic [1:0] {
        REG_DEVICE_BASE,
        REG_HOST_BASE,
        REG_REGION_LENGTH,
        REG_PAYLOAD_SIZE
    } cfg_reg_t;

    typedef struct packed {
        logic              done;
        logic              exact;
        logic [SLOT_W-1:0] quot;
    } div_res_t;

endpackage

/* hdl/absa_stack_ram.sv */
// Free-stack memory: one write port, one read port, registered read data.
// Depends on absa_pkg for depth and entry width.
module absa_stack_ram (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [absa_pkg::SLOT_W-1:0] waddr,
    input  logic [absa_pkg::SLOT_W-1:0] wdata,
    input  logic                      re,
    input  logic [absa_pkg::SLOT_W-1:0] raddr,
    output logic [absa_pkg::SLOT_W-1:0] rdata
);
    import absa_pkg::*;

    logic [SLOT_W-1:0] mem [MAX_SLOTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/absa_slot_div.sv */
// Slot index divider: restoring division, one quotient bit per cycle.
// Depends on absa_pkg for widths and the result struct.
module absa_slot_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [absa_pkg::OFF_W-1:0]    dividend,
    input  logic [absa_pkg::STRIDE_W-1:0] divisor,
    output absa_pkg::div_res_t            res
);
    import absa_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [OFF_W-1:0]  rem_reg;
    logic [OFF_W-1:0]  dsh_reg;
    logic [SLOT_W-1:0] quot_reg;
    logic              ge;
    logic [OFF_W-1:0]  rem_step;

    assign ge       = rem_reg >= dsh_reg;
    assign rem_step = ge ? rem_reg - dsh_reg : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SLOT_W - 1);
            end else if (busy_reg) begin
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend;
            dsh_reg  <= {1'b0, divisor, {(SLOT_W - 1){1'b0}}};
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_step;
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[SLOT_W-2:0], ge};
        end
    end

    assign res.done  = done_reg;
    assign res.exact = (rem_reg == '0);
    assign res.quot  = quot_reg;

endmodule

/* hdl/aligned_buffer_slot_allocator.sv */
// Aligned buffer slot allocator top level: control, pool registers, output register.
// Depends on absa_pkg, absa_stack_ram and absa_slot_div.
// Get reads the free stack, then multiplies and adds (S_GET_MUL, S_GET_ADD); return
// checks the address and may run the divider (one quotient bit per cycle); rebuild
// counts slots, one slot per cycle, then does one free-stack write per cycle.
// One item at a time; the next transfer is taken the cycle after the result is registered.
// Reset: empty pool, zero slot count, registers at reset values; the free-stack memory is
// not cleared, it is written by the next rebuild before any read.
module aligned_buffer_slot_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [absa_pkg::S_TDATA_W-1:0]  s_tdata,   // [63:0] return_address
    input  logic [absa_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [absa_pkg::M_TDATA_W-1:0]  m_tdata,   // [63:0] out_device_address,
                                                       // [127:64] out_host_address,
                                                       // [143:128] out_length,
                                                       // [150:144] pool_count, [151] zero
    output logic [absa_pkg::M_TUSER_W-1:0]  m_tuser,   // [1:0] status
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [absa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [absa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import absa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD_COUNT,
        S_BUILD_FILL,
        S_GET_MUL,
        S_GET_ADD,
        S_RET_EVAL,
        S_RET_DIV,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  device_base_reg, device_base_next;
    logic [ADDR_W-1:0]  host_base_reg, host_base_next;
    logic [LEN_W-1:0]   region_length_reg, region_length_next;
    logic [SIZE_W-1:0]  payload_size_reg, payload_size_next;
    logic [ADDR_W-1:0]  first_dev_reg, first_dev_next;
    logic [ADDR_W-1:0]  first_host_reg, first_host_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   depth_reg, depth_next;
    logic [MAX_SLOTS-1:0] in_use_reg, in_use_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ADDR_W-1:0]  ret_addr_reg, ret_addr_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    status_t            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_dev_reg, res_dev_next;
    logic [ADDR_W-1:0]  res_host_reg, res_host_next;
    logic [SIZE_W-1:0]  res_len_reg, res_len_next;
    logic               m_tvalid_reg, m_tvalid_next;
    status_t            m_status_reg, m_status_next;
    logic [ADDR_W-1:0]  m_dev_reg, m_dev_next;
    logic [ADDR_W-1:0]  m_host_reg, m_host_next;
    logic [SIZE_W-1:0]  m_len_reg, m_len_next;
    logic [CNT_W-1:0]   m_count_reg, m_count_next;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [SLOT_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [SLOT_W-1:0]  ram_rdata;
    logic               div_start;
    div_res_t           div_res;

    logic [ALIGN_W-1:0]  base_pad;
    logic [ALIGN_W-1:0]  size_pad;
    logic [STRIDE_W-1:0] stride_new;
    logic [CNT_W-1:0]    depth_dec;
    logic [CNT_W-1:0]    fill_val;
    logic [ADDR_W-1:0]   diff;
    logic [MAX_SLOTS-1:0] low_onehot;
    logic [SLOT_W-1:0]   low_idx;
    logic                out_free;

    absa_stack_ram u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    absa_slot_div u_slot_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff[OFF_W-1:0]),
        .divisor  (stride_reg),
        .res      (div_res)
    );

    assign base_pad   = -device_base_reg[ALIGN_W-1:0];
    assign size_pad   = -payload_size_reg[ALIGN_W-1:0];
    assign stride_new = {1'b0, payload_size_reg} + STRIDE_W'(size_pad);
    assign depth_dec  = depth_reg - CNT_W'(1);
    assign fill_val   = total_reg - cnt_reg - CNT_W'(1);
    assign diff       = ret_addr_reg - first_dev_reg;
    assign low_onehot = in_use_reg & (~in_use_reg + MAX_SLOTS'(1));
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        low_idx = '0;
        for (int k = 0; k < MAX_SLOTS; k++) begin
            if (low_onehot[k]) begin
                low_idx = low_idx | SLOT_W'(k);
            end
        end
    end

    always_comb begin
        state_next         = state_reg;
        device_base_next   = device_base_reg;
        host_base_next     = host_base_reg;
        region_length_next = region_length_reg;
        payload_size_next  = payload_size_reg;
        first_dev_next     = first_dev_reg;
        first_host_next    = first_host_reg;
        stride_next        = stride_reg;
        size_next          = size_reg;
        total_next         = total_reg;
        depth_next         = depth_reg;
        in_use_next        = in_use_reg;
        cnt_next           = cnt_reg;
        acc_next           = acc_reg;
        ret_addr_next      = ret_addr_reg;
        off_next           = off_reg;
        res_status_next    = res_status_reg;
        res_dev_next       = res_dev_reg;
        res_host_next      = res_host_reg;
        res_len_next       = res_len_reg;
        m_tvalid_next      = m_tvalid_reg;
        m_status_next      = m_status_reg;
        m_dev_next         = m_dev_reg;
        m_host_next        = m_host_reg;
        m_len_next         = m_len_reg;
        m_count_next       = m_count_reg;
        ram_we             = 1'b0;
        ram_waddr          = depth_reg[SLOT_W-1:0];
        ram_wdata          = low_idx;
        ram_re             = 1'b0;
        ram_raddr          = depth_dec[SLOT_W-1:0];
        div_start          = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEVICE_BASE:   device_base_next   = cfg_data;
                REG_HOST_BASE:     host_base_next     = cfg_data;
                REG_REGION_LENGTH: region_length_next = cfg_data[LEN_W-1:0];
                REG_PAYLOAD_SIZE:  payload_size_next  = cfg_data[SIZE_W-1:0];
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ret_addr_next   = s_tdata[ADDR_W-1:0];
                    res_status_next = ST_OK;
                    res_dev_next    = '0;
                    res_host_next   = '0;
                    res_len_next    = '0;
                    unique case (opcode_t'(s_tuser))
                        OP_REBUILD: begin
                            first_dev_next  = device_base_reg + ADDR_W'(base_pad);
                            first_host_next = host_base_reg + ADDR_W'(base_pad);
                            stride_next     = stride_new;
                            size_next       = payload_size_reg;
                            acc_next        = ACC_W'(base_pad) + ACC_W'(payload_size_reg);
                            cnt_next        = '0;
                            in_use_next     = '0;
                            state_next      = S_BUILD_COUNT;
                        end
                        OP_GET: begin
                            if (depth_reg == '0) begin
                                res_status_next = ST_NO_FREE;
                                state_next      = S_FINISH;
                            end else begin
                                ram_re     = 1'b1;
                                depth_next = depth_dec;
                                state_next = S_GET_MUL;
                            end
                        end
                        OP_RETURN: begin
                            state_next = S_RET_EVAL;
                        end
                        OP_NONE: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_BUILD_COUNT: begin
                if (cnt_reg != CNT_W'(MAX_SLOTS) && LEN_W'(acc_reg) <= region_length_reg) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    acc_next = acc_reg + ACC_W'(stride_reg);
                end else begin
                    total_next = cnt_reg;
                    depth_next = cnt_reg;
                    cnt_next   = '0;
                    state_next = S_BUILD_FILL;
                end
            end
            S_BUILD_FILL: begin
                if (cnt_reg == total_reg) begin
                    state_next = S_FINISH;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[SLOT_W-1:0];
                    ram_wdata = fill_val[SLOT_W-1:0];
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            S_GET_MUL: begin
                in_use_next[ram_rdata] = 1'b1;
                off_next   = OFF_W'(ram_rdata) * OFF_W'(stride_reg);
                state_next = S_GET_ADD;
            end
            S_GET_ADD: begin
                res_dev_next  = first_dev_reg + ADDR_W'(off_reg);
                res_host_next = first_host_reg + ADDR_W'(off_reg);
                res_len_next  = size_reg;
                state_next    = S_FINISH;
            end
            S_RET_EVAL: begin
                state_next = S_FINISH;
                if (in_use_reg == '0) begin
                    res_status_next = ST_NONE_IN_USE;
                end else if (stride_reg == '0) begin
                    if (diff == '0) begin
                        if (depth_reg != CNT_W'(MAX_SLOTS)) begin
                            ram_we               = 1'b1;
                            in_use_next[low_idx] = 1'b0;
                            depth_next           = depth_reg + CNT_W'(1);
                        end
                    end else begin
                        res_status_next = ST_NO_MATCH;
                    end
                end else if (diff[ADDR_W-1:OFF_W] == '0 &&
                             diff[OFF_W-1:0] < {stride_reg, {SLOT_W{1'b0}}}) begin
                    div_start  = 1'b1;
                    state_next = S_RET_DIV;
                end else begin
                    res_status_next = ST_NO_MATCH;
                end
            end
            S_RET_DIV: begin
                if (div_res.done) begin
                    state_next = S_FINISH;
                    if (div_res.exact && in_use_reg[div_res.quot]) begin
                        if (depth_reg != CNT_W'(MAX_SLOTS)) begin
                            ram_we                    = 1'b1;
                            ram_wdata                 = div_res.quot;
                            in_use_next[div_res.quot] = 1'b0;
                            depth_next                = depth_reg + CNT_W'(1);
                        end
                    end else begin
                        res_status_next = ST_NO_MATCH;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_dev_next    = res_dev_reg;
                    m_host_next   = res_host_reg;
                    m_len_next    = res_len_reg;
                    m_count_next  = total_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            device_base_reg   <= '0;
            host_base_reg     <= '0;
            region_length_reg <= '0;
            payload_size_reg  <= SIZE_W'(256);
            first_dev_reg     <= '0;
            first_host_reg    <= '0;
            stride_reg        <= '0;
            size_reg          <= '0;
            total_reg         <= '0;
            depth_reg         <= '0;
            in_use_reg        <= '0;
            cnt_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            device_base_reg   <= device_base_next;
            host_base_reg     <= host_base_next;
            region_length_reg <= region_length_next;
            payload_size_reg  <= payload_size_next;
            first_dev_reg     <= first_dev_next;
            first_host_reg    <= first_host_next;
            stride_reg        <= stride_next;
            size_reg          <= size_next;
            total_reg         <= total_next;
            depth_reg         <= depth_next;
            in_use_reg        <= in_use_next;
            cnt_reg           <= cnt_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
        acc_reg        <= acc_next;
        ret_addr_reg   <= ret_addr_next;
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_dev_reg    <= res_dev_next;
        res_host_reg   <= res_host_next;
        res_len_reg    <= res_len_next;
        m_status_reg   <= m_status_next;
        m_dev_reg      <= m_dev_next;
        m_host_reg     <= m_host_next;
        m_len_reg      <= m_len_next;
        m_count_reg    <= m_count_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_status_reg;
    assign m_tdata   = {1'b0, m_count_reg, m_len_reg, m_host_reg, m_dev_reg};

endmodule
